// File: hw/rtl/dqn_pkg.sv
// ----------------------------------------------------------------------------
// dqn_pkg
// Shared types and constants of the query name normaliser.
// ----------------------------------------------------------------------------
package dqn_pkg;

	localparam int MAX_NAME_BYTES_DEF = 64;

	localparam logic [7:0] PTR_BITS   = 8'hC0;
	localparam logic [7:0] LABEL_MAX  = 8'd63;
	localparam logic [5:0] CHAR_LIMIT = 6'd63;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UZ    = 8'h5A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADLEN  = 2'd1,
		ST_TOOLONG = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic [5:0] label_remaining;
		logic       label_seen;
		logic [5:0] chars_out;
		logic       finished;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       name_done;
		status_t    status;
		logic [5:0] name_length;
	} result_t;

endpackage

// File: hw/rtl/dns_qname_normalizer.sv
// ----------------------------------------------------------------------------
// dns_qname_normalizer
// Decodes a wire-format query name, one byte per item, into lowercase text.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_stall is low; the parse state
// updates once per byte. An item passes an input register and a result
// register before its result is offered.
// Reset: asynchronous, active low; parse state clears and the block idles
// until an item marked as the first byte of a name arrives.
module dns_qname_normalizer #(
	parameter int MAX_NAME_BYTES = dqn_pkg::MAX_NAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       name_done,
	output logic [1:0] status,
	output logic [5:0] name_length
);

	localparam int BS_W = $clog2(MAX_NAME_BYTES + 1);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  valid_s2;
	dqn_pkg::result_t      result_s2;
	dqn_pkg::parse_state_t state_q;
	logic [BS_W-1:0]       scanned_q;
	dqn_pkg::parse_state_t state_nxt;
	logic [BS_W-1:0]       scanned_nxt;
	dqn_pkg::result_t      result_nxt;
	logic                  adv_s2;
	logic                  load_s1;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || adv_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1  <= in_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	dqn_decode #(
		.MAX_NAME_BYTES(MAX_NAME_BYTES),
		.BS_W          (BS_W)
	) u_decode (
		.in_byte    (byte_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.cur_state  (state_q),
		.cur_scanned(scanned_q),
		.nxt_state  (state_nxt),
		.nxt_scanned(scanned_nxt),
		.result     (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.label_remaining <= 6'd0;
			state_q.label_seen      <= 1'b0;
			state_q.chars_out       <= 6'd0;
			state_q.finished        <= 1'b1;
			scanned_q               <= '0;
			valid_s2                <= 1'b0;
		end else begin
			if (adv_s2) begin
				state_q   <= state_nxt;
				scanned_q <= scanned_nxt;
			end
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign out_char    = result_s2.out_char;
	assign char_valid  = result_s2.char_valid;
	assign name_done   = result_s2.name_done;
	assign status      = result_s2.status;
	assign name_length = result_s2.name_length;

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s1 |=> !out_valid)
		else $error("result offered twice");

	a_char_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> name_length != 6'd0)
		else $error("character emitted without being counted");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(state_q) && $stable(scanned_q))
		else $error("parse state changed without an item advancing");
`endif

endmodule

// File: hw/rtl/dqn_decode.sv
// ----------------------------------------------------------------------------
// dqn_decode
// Per-byte label decoding: next parse state and the result for one item.
// ----------------------------------------------------------------------------
module dqn_decode #(
	parameter int MAX_NAME_BYTES = dqn_pkg::MAX_NAME_BYTES_DEF,
	parameter int BS_W = $clog2(MAX_NAME_BYTES + 1)
) (
	input  logic [7:0]            in_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	input  dqn_pkg::parse_state_t cur_state,
	input  logic [BS_W-1:0]       cur_scanned,
	output dqn_pkg::parse_state_t nxt_state,
	output logic [BS_W-1:0]       nxt_scanned,
	output dqn_pkg::result_t      result
);

	localparam logic [BS_W-1:0] SCAN_MAX = BS_W'(MAX_NAME_BYTES);

	always_comb begin
		dqn_pkg::parse_state_t st;
		logic [BS_W-1:0]       bs;
		logic [7:0]            ch;
		logic                  valid;
		logic                  done;
		dqn_pkg::status_t      status;

		st     = cur_state;
		bs     = cur_scanned;
		ch     = 8'd0;
		valid  = 1'b0;
		done   = 1'b0;
		status = dqn_pkg::ST_OK;

		if (first_byte) begin
			st.label_remaining = 6'd0;
			st.label_seen      = 1'b0;
			st.chars_out       = 6'd0;
			st.finished        = 1'b0;
			bs                 = '0;
		end

		if (!st.finished) begin
			if (bs < SCAN_MAX) begin
				bs = bs + 1'b1;
			end
			if (st.label_remaining == 6'd0) begin
				priority if (in_byte == 8'd0) begin
					done   = 1'b1;
					status = st.label_seen ? dqn_pkg::ST_OK : dqn_pkg::ST_INVALID;
				end else if ((in_byte & dqn_pkg::PTR_BITS) != 8'd0
						|| in_byte > dqn_pkg::LABEL_MAX) begin
					done   = 1'b1;
					status = dqn_pkg::ST_BADLEN;
				end else if (st.label_seen && st.chars_out >= dqn_pkg::CHAR_LIMIT) begin
					done   = 1'b1;
					status = dqn_pkg::ST_TOOLONG;
				end else begin
					if (st.label_seen) begin
						ch           = dqn_pkg::CHAR_DOT;
						valid        = 1'b1;
						st.chars_out = st.chars_out + 6'd1;
					end
					st.label_remaining = in_byte[5:0];
					st.label_seen      = 1'b1;
				end
			end else begin
				if (st.chars_out >= dqn_pkg::CHAR_LIMIT) begin
					done   = 1'b1;
					status = dqn_pkg::ST_TOOLONG;
				end else begin
					if (in_byte >= dqn_pkg::CHAR_UA && in_byte <= dqn_pkg::CHAR_UZ) begin
						ch = in_byte + dqn_pkg::CASE_DIFF;
					end else begin
						ch = in_byte;
					end
					valid              = 1'b1;
					st.chars_out       = st.chars_out + 6'd1;
					st.label_remaining = st.label_remaining - 6'd1;
				end
			end

			if (!done && bs >= SCAN_MAX) begin
				done   = 1'b1;
				status = dqn_pkg::ST_TOOLONG;
			end
			if (!done && last_byte) begin
				done   = 1'b1;
				status = dqn_pkg::ST_INVALID;
			end
			if (done) begin
				st.finished = 1'b1;
			end
		end

		nxt_state          = st;
		nxt_scanned        = bs;
		result.out_char    = ch;
		result.char_valid  = valid;
		result.name_done   = done;
		result.status      = status;
		result.name_length = st.chars_out;
	end

endmodule

// File: sim/tb_dns_qname_normalizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_qname_normalizer
// Streams wire-format query names through the normaliser under random source
// gaps and sink stalls. Each accepted byte is decoded by a behavioural model
// in the bench, and every result item is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_dns_qname_normalizer;

	localparam int SCAN_LIMIT = dqn_pkg::MAX_NAME_BYTES_DEF;
	localparam int ITEM_GOAL  = 550;

	typedef struct {
		logic [7:0] b;
		logic       fb;
		logic       lb;
		bit         drain;
	} wire_byte_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       first_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       char_valid;
	logic       name_done;
	logic [1:0] status;
	logic [5:0] name_length;

	wire_byte_t       wire_q[$];
	dqn_pkg::result_t decoded_q[$];

	logic [5:0] lab_left;
	logic       lab_seen;
	logic [5:0] n_chars;
	int         n_scanned;
	logic       idle;

	bit item_loaded;
	bit jitter;
	bit tail;
	int src_gap;
	int snk_gap;
	int n_err;
	int n_items;
	int next_drain;
	bit open_name;

	dns_qname_normalizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.char_valid (char_valid),
		.name_done  (name_done),
		.status     (status),
		.name_length(name_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic decode_byte(input logic [7:0] b, input logic fb, input logic lb,
			output dqn_pkg::result_t r);
		logic [7:0] c;
		r = '0;
		c = b;
		if (fb) begin
			lab_left  = '0;
			lab_seen  = 1'b0;
			n_chars   = '0;
			n_scanned = 0;
			idle      = 1'b0;
		end
		if (!idle) begin
			if (n_scanned < SCAN_LIMIT)
				n_scanned++;
			if (lab_left == 0) begin
				if (b == 8'd0) begin
					r.name_done = 1'b1;
					if (lab_seen)
						r.status = dqn_pkg::ST_OK;
					else
						r.status = dqn_pkg::ST_INVALID;
				end else if ((b & dqn_pkg::PTR_BITS) != 0 || b > dqn_pkg::LABEL_MAX) begin
					r.name_done = 1'b1;
					r.status    = dqn_pkg::ST_BADLEN;
				end else if (lab_seen && n_chars >= dqn_pkg::CHAR_LIMIT) begin
					r.name_done = 1'b1;
					r.status    = dqn_pkg::ST_TOOLONG;
				end else begin
					if (lab_seen) begin
						r.out_char   = dqn_pkg::CHAR_DOT;
						r.char_valid = 1'b1;
						n_chars++;
					end
					lab_left = b[5:0];
					lab_seen = 1'b1;
				end
			end else begin
				if (n_chars >= dqn_pkg::CHAR_LIMIT) begin
					r.name_done = 1'b1;
					r.status    = dqn_pkg::ST_TOOLONG;
				end else begin
					if (b >= dqn_pkg::CHAR_UA && b <= dqn_pkg::CHAR_UZ)
						c = b + dqn_pkg::CASE_DIFF;
					r.out_char   = c;
					r.char_valid = 1'b1;
					n_chars++;
					lab_left--;
				end
			end
			if (!r.name_done && n_scanned >= SCAN_LIMIT) begin
				r.name_done = 1'b1;
				r.status    = dqn_pkg::ST_TOOLONG;
			end
			if (!r.name_done && lb) begin
				r.name_done = 1'b1;
				r.status    = dqn_pkg::ST_INVALID;
			end
			if (r.name_done)
				idle = 1'b1;
		end
		r.name_length = n_chars;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fb, input logic lb,
			input bit counted);
		wire_byte_t w;
		w.b     = b;
		w.fb    = fb;
		w.lb    = lb;
		w.drain = 1'b0;
		if (fb && n_items >= next_drain) begin
			w.drain    = 1'b1;
			next_drain = next_drain + 150;
		end
		wire_q.push_back(w);
		if (counted)
			n_items++;
	endtask

	function automatic logic [7:0] label_char();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return 8'($urandom_range(dqn_pkg::CHAR_UA, dqn_pkg::CHAR_UZ));
		else if (k < 7)
			return 8'($urandom_range(8'h61, 8'h7A));
		return 8'($urandom_range(0, 255));
	endfunction

	// Builds the wire bytes of a name from random labels, optionally cut short
	// with last_byte on the cut, and pushes them.
	task automatic push_name(input int n_labels, input int len_lo, input int len_hi,
			input bit with_end, input bit truncate);
		logic [7:0] bytes[$];
		int len;
		int cut;
		bytes = {};
		for (int i = 0; i < n_labels; i++) begin
			len = $urandom_range(len_lo, len_hi);
			bytes.push_back(8'(len));
			for (int j = 0; j < len; j++)
				bytes.push_back(label_char());
		end
		if (with_end)
			bytes.push_back(8'd0);
		cut = truncate ? $urandom_range(0, bytes.size() - 1) : bytes.size() - 1;
		for (int i = 0; i <= cut; i++)
			push_byte(bytes[i], i == 0, i == cut && (truncate ||
				(with_end && $urandom_range(0, 4) == 0)), 1'b1);
	endtask

	always @(posedge clk) begin
		dqn_pkg::result_t r;
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(in_byte, first_byte, last_byte, r);
			decoded_q.push_back(r);
			item_loaded = 1'b0;
		end
	end

	always @(negedge clk) begin
		wire_byte_t w;
		bit nv;
		if (arst_n) begin
			if ($urandom_range(0, 39) == 0)
				jitter = !jitter;
			tail = wire_q.size() < 80;
			if (!item_loaded) begin
				nv = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (wire_q.size() > 0 &&
						!(wire_q[0].drain && decoded_q.size() != 0)) begin
					w = wire_q.pop_front();
					in_byte    <= w.b;
					first_byte <= w.fb;
					last_byte  <= w.lb;
					nv          = 1'b1;
					item_loaded = 1'b1;
					if (jitter && !tail && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 10);
				end
				in_valid <= nv;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0)
				snk_gap--;
			else if (jitter && !tail && $urandom_range(0, 5) == 0)
				snk_gap = $urandom_range(1, 10);
			out_stall <= (snk_gap != 0);
		end
	end

	always @(posedge clk) begin
		dqn_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("Unexpected result item: char %h len %0d", out_char,
						name_length);
			end else begin
				want = decoded_q.pop_front();
				if (want.out_char !== out_char || want.char_valid !== char_valid ||
						want.name_done !== name_done || want.status !== status ||
						want.name_length !== name_length) begin
					n_err++;
					if (n_err <= 10)
						$display({"Mismatch: expected char %h valid %b done %b ",
							"status %0d len %0d, got char %h valid %b done %b ",
							"status %0d len %0d"},
							want.out_char, want.char_valid, want.name_done,
							want.status, want.name_length, out_char, char_valid,
							name_done, status, name_length);
				end
			end
		end
	end

	initial begin
		int kind;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_byte     = '0;
		first_byte  = 1'b0;
		last_byte   = 1'b0;
		out_stall   = 1'b0;
		item_loaded = 1'b0;
		jitter      = 1'b0;
		tail        = 1'b0;
		src_gap     = 0;
		snk_gap     = 0;
		n_err       = 0;
		n_items     = 0;
		next_drain  = 30;
		open_name   = 1'b0;
		lab_left    = '0;
		lab_seen    = 1'b0;
		n_chars     = '0;
		n_scanned   = 0;
		idle        = 1'b1;

		// A byte before any name start is ignored.
		push_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		// Case folding at the edges of the upper-case range.
		push_byte(8'h04, 1'b1, 1'b0, 1'b1);
		push_byte(8'h40, 1'b0, 1'b0, 1'b1);
		push_byte(dqn_pkg::CHAR_UA, 1'b0, 1'b0, 1'b1);
		push_byte(dqn_pkg::CHAR_UZ, 1'b0, 1'b0, 1'b1);
		push_byte(8'h5B, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		// Empty name, compression pointer and a label length of 64.
		push_byte(8'h00, 1'b1, 1'b0, 1'b1);
		push_byte(dqn_pkg::PTR_BITS, 1'b1, 1'b0, 1'b1);
		push_byte(8'h40, 1'b1, 1'b0, 1'b1);
		// Longest label, cut short after one content byte.
		push_byte(dqn_pkg::LABEL_MAX, 1'b1, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b0, 1'b1, 1'b1);
		// Data ends on a label length byte, which still yields its dot.
		push_byte(8'h01, 1'b1, 1'b0, 1'b1);
		push_byte(8'h61, 1'b0, 1'b0, 1'b1);
		push_byte(8'h02, 1'b0, 1'b1, 1'b1);
		// A new name starting in the middle of another.
		push_byte(8'h02, 1'b1, 1'b0, 1'b1);
		push_byte(8'h61, 1'b0, 1'b0, 1'b1);
		push_byte(8'h01, 1'b1, 1'b0, 1'b1);
		push_byte(8'h62, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		push_byte(8'h55, 1'b0, 1'b1, 1'b1);
		// The terminator takes precedence over the end of data.
		push_byte(8'h01, 1'b1, 1'b0, 1'b1);
		push_byte(dqn_pkg::CHAR_UZ, 1'b0, 1'b0, 1'b1);
		push_byte(8'h00, 1'b0, 1'b1, 1'b1);

		while (n_items < ITEM_GOAL) begin
			kind = $urandom_range(0, 99);
			if (kind >= 94 && open_name)
				kind = 90;
			if (kind < 60) begin
				if ($urandom_range(0, 9) == 0)
					push_name($urandom_range(1, 2), 20, 63, 1'b1,
						$urandom_range(0, 6) == 0);
				else
					push_name($urandom_range(1, 4), 1, 8, 1'b1,
						$urandom_range(0, 6) == 0);
				open_name = 1'b0;
			end else if (kind < 70) begin
				push_name($urandom_range(4, 8), 8, 20, 1'b0, 1'b0);
				open_name = 1'b0;
			end else if (kind < 80) begin
				push_name($urandom_range(1, 3), 1, 6, 1'b0, 1'b0);
				push_byte(8'($urandom_range(64, 255)), 1'b0, 1'($urandom_range(0, 1)),
					1'b1);
				open_name = 1'b0;
			end else if (kind < 87) begin
				push_byte(8'h00, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
				open_name = 1'b0;
			end else if (kind < 94) begin
				push_name($urandom_range(1, 3), 1, 6, 1'b0, 1'b0);
				open_name = 1'b1;
			end else begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(0, 255)), 1'b0,
						1'($urandom_range(0, 1)), 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (wire_q.size() != 0 || item_loaded || decoded_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_err == 0)
			$display("tb_dns_qname_normalizer: clean");
		else
			$display("tb_dns_qname_normalizer: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_dns_qname_normalizer: errors");
		$finish;
	end

endmodule
